// File: rtl/cfcp_pkg.sv
// Shared types, codes and layout tables for the class file constant pool parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cfcp_pkg;

  // Parse phases of the byte walker
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_FIELDS = 3'd2,
    PH_UTF8   = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_e;

  // Token kinds as seen on field_kind
  typedef enum logic [3:0] {
    KIND_MAGIC      = 4'd0,
    KIND_MINOR      = 4'd1,
    KIND_MAJOR      = 4'd2,
    KIND_POOL_COUNT = 4'd3,
    KIND_TAG        = 4'd4,
    KIND_REF_KIND   = 4'd5,
    KIND_INDEX_A    = 4'd6,
    KIND_INDEX_B    = 4'd7,
    KIND_U4         = 4'd8,
    KIND_HIGH       = 4'd9,
    KIND_LOW        = 4'd10,
    KIND_UTF8_LEN   = 4'd11,
    KIND_UTF8_BYTE  = 4'd12,
    KIND_BAD_TAG    = 4'd13
  } kind_e;

  // Constant pool tags
  localparam logic [7:0] TAG_UTF8       = 8'd1;
  localparam logic [7:0] TAG_INT        = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAME_TYPE  = 8'd12;
  localparam logic [7:0] TAG_MHANDLE    = 8'd15;
  localparam logic [7:0] TAG_MTYPE      = 8'd16;
  localparam logic [7:0] TAG_INDY       = 8'd18;

  // Header: magic is u4, the rest are u2; pool count is the last header field
  localparam logic [3:0] HDR_LAST_POS   = 4'd3;
  localparam logic [2:0] HDR_MAGIC_SIZE = 3'd4;
  localparam logic [2:0] HDR_U2_SIZE    = 3'd2;

  // One output transaction
  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [15:0] entry;
    logic [7:0]  tag;
    logic        pool_end;
  } token_t;

  // Field lookup result: valid is low past the end of an entry's layout
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } layout_t;

  // Field kind at position pos of an entry with the given tag
  function automatic layout_t layout(input logic [7:0] tag, input logic [3:0] pos);
    layout_t res;
    res.valid = 1'b0;
    res.kind  = KIND_INDEX_A;
    case (tag) inside
      TAG_UTF8: begin
        res.valid = (pos == 4'd0);
        res.kind  = KIND_UTF8_LEN;
      end
      TAG_INT, TAG_FLOAT: begin
        res.valid = (pos == 4'd0);
        res.kind  = KIND_U4;
      end
      TAG_LONG, TAG_DOUBLE: begin
        res.valid = (pos == 4'd0) || (pos == 4'd1);
        res.kind  = (pos == 4'd0) ? KIND_HIGH : KIND_LOW;
      end
      TAG_CLASS, TAG_STRING, TAG_MTYPE: begin
        res.valid = (pos == 4'd0);
        res.kind  = KIND_INDEX_A;
      end
      TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAME_TYPE, TAG_INDY: begin
        res.valid = (pos == 4'd0) || (pos == 4'd1);
        res.kind  = (pos == 4'd0) ? KIND_INDEX_A : KIND_INDEX_B;
      end
      TAG_MHANDLE: begin
        res.valid = (pos == 4'd0) || (pos == 4'd1);
        res.kind  = (pos == 4'd0) ? KIND_REF_KIND : KIND_INDEX_A;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Byte size of an entry field
  function automatic logic [2:0] kind_size(input kind_e kind);
    logic [2:0] sz;
    case (kind) inside
      KIND_REF_KIND:               sz = 3'd1;
      KIND_U4, KIND_HIGH, KIND_LOW: sz = 3'd4;
      default:                     sz = 3'd2;
    endcase
    return sz;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cfcp_front.sv
// Front end: takes class file bytes, tracks header/entry position and builds tokens.
// Depends on cfcp_pkg for phases, kinds, tags and the layout table.
`timescale 1ns / 1ps
`default_nettype none

module cfcp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           file_start_i,
  output cfcp_pkg::token_t    token_o,
  output logic                push_o
);

  cfcp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [1:0]  bcnt_q, bcnt_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  tag_q, tag_d;
  logic [15:0] entry_q, entry_d;
  logic [15:0] pool_q, pool_d;
  logic [15:0] rem_q, rem_d;

  // State as seen by this byte: a file start clears everything first
  cfcp_pkg::phase_e ph_e;
  logic [3:0]  pos_e;
  logic [1:0]  bcnt_e;
  logic [31:0] acc_e;
  logic [7:0]  tag_e;
  logic [15:0] entry_e;
  logic [15:0] pool_e;
  logic [15:0] rem_e;

  assign ph_e    = file_start_i ? cfcp_pkg::PH_HEADER : phase_q;
  assign pos_e   = file_start_i ? 4'd0  : pos_q;
  assign bcnt_e  = file_start_i ? 2'd0  : bcnt_q;
  assign acc_e   = file_start_i ? 32'd0 : acc_q;
  assign tag_e   = file_start_i ? 8'd0  : tag_q;
  assign entry_e = file_start_i ? 16'd0 : entry_q;
  assign pool_e  = file_start_i ? 16'd0 : pool_q;
  assign rem_e   = file_start_i ? 16'd0 : rem_q;

  // Shared decode of the current byte
  logic [31:0]           acc_shift;
  logic [2:0]            size_sel;
  logic                  gather_done;
  cfcp_pkg::layout_t     cur_layout;
  cfcp_pkg::layout_t     next_layout;
  cfcp_pkg::layout_t     tag_layout;
  logic [16:0]           next_entry;
  logic                  pool_last;
  logic [15:0]           rem_dec;
  logic                  rem_zero;
  logic                  acc_zero;

  assign acc_shift   = {acc_e[23:0], data_byte_i};
  assign cur_layout  = cfcp_pkg::layout(tag_e, pos_e);
  assign next_layout = cfcp_pkg::layout(tag_e, pos_e + 4'd1);
  assign tag_layout  = cfcp_pkg::layout(data_byte_i, 4'd0);
  assign size_sel    = (ph_e == cfcp_pkg::PH_HEADER)
                     ? ((pos_e == 4'd0) ? cfcp_pkg::HDR_MAGIC_SIZE : cfcp_pkg::HDR_U2_SIZE)
                     : cfcp_pkg::kind_size(cur_layout.kind);
  assign gather_done = ({1'b0, bcnt_e} + 3'd1) >= size_sel;
  // Long and double occupy two pool slots
  assign next_entry  = {1'b0, entry_e} +
                       (((tag_e == cfcp_pkg::TAG_LONG) || (tag_e == cfcp_pkg::TAG_DOUBLE))
                        ? 17'd2 : 17'd1);
  assign pool_last   = next_entry >= {1'b0, pool_e};
  assign rem_dec     = (rem_e != 16'd0) ? rem_e - 16'd1 : 16'd0;
  assign rem_zero    = (rem_dec == 16'd0);
  assign acc_zero    = (acc_shift == 32'd0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      phase_d = ph_e;
      case (ph_e)
        cfcp_pkg::PH_HEADER: begin
          if (gather_done && (pos_e == cfcp_pkg::HDR_LAST_POS)) begin
            phase_d = (acc_shift[15:1] == 15'd0) ? cfcp_pkg::PH_DONE : cfcp_pkg::PH_TAG;
          end
        end
        cfcp_pkg::PH_TAG: begin
          phase_d = tag_layout.valid ? cfcp_pkg::PH_FIELDS : cfcp_pkg::PH_ERROR;
        end
        cfcp_pkg::PH_FIELDS: begin
          if (!cur_layout.valid) begin
            phase_d = cfcp_pkg::PH_ERROR;
          end else if (gather_done) begin
            if (cur_layout.kind == cfcp_pkg::KIND_UTF8_LEN) begin
              if (acc_zero) begin
                phase_d = pool_last ? cfcp_pkg::PH_DONE : cfcp_pkg::PH_TAG;
              end else begin
                phase_d = cfcp_pkg::PH_UTF8;
              end
            end else if (!next_layout.valid) begin
              phase_d = pool_last ? cfcp_pkg::PH_DONE : cfcp_pkg::PH_TAG;
            end
          end
        end
        cfcp_pkg::PH_UTF8: begin
          if (rem_zero) begin
            phase_d = pool_last ? cfcp_pkg::PH_DONE : cfcp_pkg::PH_TAG;
          end
        end
        default: begin
          phase_d = ph_e;
        end
      endcase
    end
  end

  // Datapath updates and token build
  always_comb begin
    pos_d   = pos_q;
    bcnt_d  = bcnt_q;
    acc_d   = acc_q;
    tag_d   = tag_q;
    entry_d = entry_q;
    pool_d  = pool_q;
    rem_d   = rem_q;
    push_o  = 1'b0;
    token_o.kind     = cfcp_pkg::KIND_MAGIC;
    token_o.value    = acc_shift;
    token_o.entry    = entry_e;
    token_o.tag      = tag_e;
    token_o.pool_end = 1'b0;
    if (accept_i) begin
      pos_d   = pos_e;
      bcnt_d  = bcnt_e;
      acc_d   = acc_e;
      tag_d   = tag_e;
      entry_d = entry_e;
      pool_d  = pool_e;
      rem_d   = rem_e;
      case (ph_e)
        cfcp_pkg::PH_HEADER: begin
          if (!gather_done) begin
            bcnt_d = bcnt_e + 2'd1;
            acc_d  = acc_shift;
          end else begin
            bcnt_d        = 2'd0;
            acc_d         = 32'd0;
            push_o        = 1'b1;
            token_o.kind  = cfcp_pkg::kind_e'(pos_e);
            token_o.entry = 16'd0;
            token_o.tag   = 8'd0;
            if (pos_e != cfcp_pkg::HDR_LAST_POS) begin
              pos_d = pos_e + 4'd1;
            end else begin
              pool_d           = acc_shift[15:0];
              pos_d            = 4'd0;
              entry_d          = 16'd1;
              token_o.pool_end = (acc_shift[15:1] == 15'd0);
            end
          end
        end
        cfcp_pkg::PH_TAG: begin
          tag_d         = data_byte_i;
          pos_d         = 4'd0;
          bcnt_d        = 2'd0;
          acc_d         = 32'd0;
          push_o        = 1'b1;
          token_o.kind  = tag_layout.valid ? cfcp_pkg::KIND_TAG : cfcp_pkg::KIND_BAD_TAG;
          token_o.value = {24'd0, data_byte_i};
          token_o.tag   = data_byte_i;
        end
        cfcp_pkg::PH_FIELDS: begin
          if (cur_layout.valid) begin
            if (!gather_done) begin
              bcnt_d = bcnt_e + 2'd1;
              acc_d  = acc_shift;
            end else begin
              bcnt_d       = 2'd0;
              acc_d        = 32'd0;
              push_o       = 1'b1;
              token_o.kind = cur_layout.kind;
              if (cur_layout.kind == cfcp_pkg::KIND_UTF8_LEN) begin
                if (acc_zero) begin
                  // empty string closes the entry on its length
                  pos_d            = 4'd0;
                  token_o.pool_end = pool_last;
                  if (!pool_last) begin
                    entry_d = next_entry[15:0];
                  end
                end else begin
                  rem_d = acc_shift[15:0];
                end
              end else begin
                pos_d = pos_e + 4'd1;
                if (!next_layout.valid) begin
                  pos_d            = 4'd0;
                  token_o.pool_end = pool_last;
                  if (!pool_last) begin
                    entry_d = next_entry[15:0];
                  end
                end
              end
            end
          end
        end
        cfcp_pkg::PH_UTF8: begin
          rem_d         = rem_dec;
          push_o        = 1'b1;
          token_o.kind  = cfcp_pkg::KIND_UTF8_BYTE;
          token_o.value = {24'd0, data_byte_i};
          if (rem_zero) begin
            pos_d            = 4'd0;
            token_o.pool_end = pool_last;
            if (!pool_last) begin
              entry_d = next_entry[15:0];
            end
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfcp_pkg::PH_HEADER;
      pos_q   <= 4'd0;
      bcnt_q  <= 2'd0;
      acc_q   <= 32'd0;
      tag_q   <= 8'd0;
      entry_q <= 16'd0;
      pool_q  <= 16'd0;
      rem_q   <= 16'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      bcnt_q  <= bcnt_d;
      acc_q   <= acc_d;
      tag_q   <= tag_d;
      entry_q <= entry_d;
      pool_q  <= pool_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfcp_fifo.sv
// Token queue between the parser front end and the output stage.
// Depends on cfcp_pkg for the token type.
`timescale 1ns / 1ps
`default_nettype none

module cfcp_fifo #(
  parameter int Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire cfcp_pkg::token_t  wr_data_i,
  output logic                   full_o,
  input  wire logic              rd_en_i,
  output logic                   rd_valid_o,
  output cfcp_pkg::token_t       rd_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cfcp_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfcp_back.sv
// Back end: output register that drains the token queue onto the result port.
// Depends on cfcp_pkg for the token type.
`timescale 1ns / 1ps
`default_nettype none

module cfcp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_valid_i,
  input  wire cfcp_pkg::token_t  rd_data_i,
  output logic                   rd_en_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cfcp_pkg::token_t       out_token_o
);

  logic             vld_q, vld_d;
  cfcp_pkg::token_t tok_q;

  // Load when the register is empty or its transaction leaves this cycle
  assign rd_en_o = rd_valid_i && (!vld_q || !out_stall_i);

  always_comb begin
    vld_d = vld_q;
    if (rd_en_o) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) begin
      tok_q <= rd_data_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_token_o = tok_q;

endmodule

`default_nettype wire

// File: rtl/class_file_constant_pool_parser_top.sv
// Path: a byte that completes a field has its token written into the token queue, from
// which the output register loads it onto the result port when empty or draining.
// Throughput: one byte per cycle while the token queue is not full; the queue absorbs
// output stalls until it fills, and then in_stall_o holds the input.
// Reset: asynchronous, active low; parser returns to header/magic, queue and output empty.
// Top level of the parser; instantiates cfcp_front, cfcp_fifo and cfcp_back (cfcp_pkg).
`timescale 1ns / 1ps
`default_nettype none

module class_file_constant_pool_parser_top #(
  parameter int QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        file_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       field_kind_o,
  output logic [31:0]      field_value_o,
  output logic [15:0]      entry_number_o,
  output logic [7:0]       entry_tag_o,
  output logic             pool_end_o
);

  logic             accept;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  cfcp_pkg::token_t front_tok;
  cfcp_pkg::token_t q_tok;
  cfcp_pkg::token_t out_tok;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  cfcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .token_o      (front_tok),
    .push_o       (push)
  );

  cfcp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (front_tok),
    .full_o     (q_full),
    .rd_en_i    (q_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_tok)
  );

  cfcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (q_valid),
    .rd_data_i   (q_tok),
    .rd_en_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_token_o (out_tok)
  );

  assign field_kind_o   = out_tok.kind;
  assign field_value_o  = out_tok.value;
  assign entry_number_o = out_tok.entry;
  assign entry_tag_o    = out_tok.tag;
  assign pool_end_o     = out_tok.pool_end;

endmodule

`default_nettype wire

// File: rtl/cfcp_checker.sv
// Port-level checks for the class file constant pool parser, bound to the top level.
// Depends on cfcp_pkg for the token kind codes.
`timescale 1ns / 1ps
`default_nettype none

module cfcp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  field_kind_o,
  input wire logic [31:0] field_value_o,
  input wire logic [15:0] entry_number_o,
  input wire logic [7:0]  entry_tag_o,
  input wire logic        pool_end_o
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(field_kind_o) &&
      $stable(field_value_o) && $stable(entry_number_o) && $stable(entry_tag_o) &&
      $stable(pool_end_o))
    else $error("result changed while stalled");

  // Only defined kinds appear
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_kind_o <= cfcp_pkg::KIND_BAD_TAG)
    else $error("undefined field kind");

  // Header tokens carry no entry context
  a_header_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o <= cfcp_pkg::KIND_POOL_COUNT |->
      entry_number_o == 16'd0 && entry_tag_o == 8'd0)
    else $error("header token with entry context");

  // The pool can only end on the last field of an entry or on the pool count
  a_pool_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pool_end_o |->
      field_kind_o == cfcp_pkg::KIND_POOL_COUNT || field_kind_o == cfcp_pkg::KIND_INDEX_A ||
      field_kind_o == cfcp_pkg::KIND_INDEX_B || field_kind_o == cfcp_pkg::KIND_U4 ||
      field_kind_o == cfcp_pkg::KIND_LOW || field_kind_o == cfcp_pkg::KIND_UTF8_LEN ||
      field_kind_o == cfcp_pkg::KIND_UTF8_BYTE)
    else $error("pool end on a non-final field");

  // Tag tokens carry the tag byte itself as value
  a_tag_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_kind_o == cfcp_pkg::KIND_TAG ||
      field_kind_o == cfcp_pkg::KIND_BAD_TAG) |->
      field_value_o == {24'd0, entry_tag_o})
    else $error("tag token value mismatch");

endmodule

bind class_file_constant_pool_parser_top cfcp_checker u_cfcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .field_kind_o   (field_kind_o),
  .field_value_o  (field_value_o),
  .entry_number_o (entry_number_o),
  .entry_tag_o    (entry_tag_o),
  .pool_end_o     (pool_end_o)
);

`default_nettype wire

// File: sim/tb_class_file_constant_pool_parser_top.sv
// Testbench for class_file_constant_pool_parser_top: streams class file bytes and
// checks every token against a byte-level parse model kept in this file.
// Depends on cfcp_pkg (kinds, tags, phases, token type) and the top-level RTL.
`timescale 1ns / 1ps

module tb_class_file_constant_pool_parser_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LIVE_TARGET = 600;
  localparam int DRAIN_CYCLES = 20;

  // Tags outside every layout
  localparam logic [7:0] TAG_ZERO     = 8'd0;
  localparam logic [7:0] TAG_ALL_ONES = 8'd255;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        file_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  field_kind_o;
  logic [31:0] field_value_o;
  logic [15:0] entry_number_o;
  logic [7:0]  entry_tag_o;
  logic        pool_end_o;

  class_file_constant_pool_parser_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .file_start_i   (file_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .field_kind_o   (field_kind_o),
    .field_value_o  (field_value_o),
    .entry_number_o (entry_number_o),
    .entry_tag_o    (entry_tag_o),
    .pool_end_o     (pool_end_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  byte_item_t       byte_q[$];
  cfcp_pkg::token_t tokens_due[$];
  int               live_bytes = 0;
  bit               start_next = 1'b0;
  int               bytes_sent = 0;
  int               tokens_taken = 0;
  int               fails = 0;
  int               cycles = 0;
  bit               in_fire = 1'b0;
  bit               out_fire = 1'b0;
  int               gap_left = 0;
  int               hold_left = 0;

  // ---------------------------------------------------------------------------
  // Parse model state
  cfcp_pkg::phase_e walk_phase;
  logic [3:0]       walk_pos;
  logic [1:0]       gathered;
  logic [31:0]      shift_acc;
  logic [7:0]       cur_tag;
  logic [15:0]      cur_entry;
  logic [15:0]      pool_count;
  logic [15:0]      utf8_left;

  function automatic void clear_walker();
    walk_phase = cfcp_pkg::PH_HEADER;
    walk_pos   = 4'd0;
    gathered   = 2'd0;
    shift_acc  = 32'd0;
    cur_tag    = 8'd0;
    cur_entry  = 16'd0;
    pool_count = 16'd0;
    utf8_left  = 16'd0;
  endfunction

  // Kind of field number pos within an entry; valid low past the layout
  function automatic cfcp_pkg::layout_t entry_slot(input logic [7:0] tag,
                                                   input logic [3:0] pos);
    cfcp_pkg::layout_t s;
    cfcp_pkg::kind_e   first;
    cfcp_pkg::kind_e   second;
    int                nfields;
    first   = cfcp_pkg::KIND_INDEX_A;
    second  = cfcp_pkg::KIND_INDEX_A;
    nfields = 0;
    case (tag)
      cfcp_pkg::TAG_UTF8: begin
        nfields = 1;
        first   = cfcp_pkg::KIND_UTF8_LEN;
      end
      cfcp_pkg::TAG_INT, cfcp_pkg::TAG_FLOAT: begin
        nfields = 1;
        first   = cfcp_pkg::KIND_U4;
      end
      cfcp_pkg::TAG_LONG, cfcp_pkg::TAG_DOUBLE: begin
        nfields = 2;
        first   = cfcp_pkg::KIND_HIGH;
        second  = cfcp_pkg::KIND_LOW;
      end
      cfcp_pkg::TAG_CLASS, cfcp_pkg::TAG_STRING, cfcp_pkg::TAG_MTYPE: begin
        nfields = 1;
      end
      cfcp_pkg::TAG_FIELDREF, cfcp_pkg::TAG_METHODREF, cfcp_pkg::TAG_IMETHODREF,
      cfcp_pkg::TAG_NAME_TYPE, cfcp_pkg::TAG_INDY: begin
        nfields = 2;
        second  = cfcp_pkg::KIND_INDEX_B;
      end
      cfcp_pkg::TAG_MHANDLE: begin
        nfields = 2;
        first   = cfcp_pkg::KIND_REF_KIND;
      end
      default: nfields = 0;
    endcase
    s.valid = (int'(pos) < nfields);
    s.kind  = (pos == 4'd0) ? first : second;
    return s;
  endfunction

  function automatic logic [2:0] field_bytes(input cfcp_pkg::kind_e k);
    if (k == cfcp_pkg::KIND_REF_KIND) return 3'd1;
    if (k == cfcp_pkg::KIND_U4 || k == cfcp_pkg::KIND_HIGH || k == cfcp_pkg::KIND_LOW)
      return 3'd4;
    return 3'd2;
  endfunction

  // Shift one byte in; high when the field of need bytes is complete
  function automatic bit take_byte(input logic [7:0] b, input logic [2:0] need);
    shift_acc = {shift_acc[23:0], b};
    if ({1'b0, gathered} + 3'd1 < need) begin
      gathered = gathered + 2'd1;
      return 1'b0;
    end
    gathered = 2'd0;
    return 1'b1;
  endfunction

  // Step to the next entry; long and double take two slots. High when pool ends.
  function automatic logic close_entry();
    logic [16:0] nxt;
    nxt = {1'b0, cur_entry} +
          ((cur_tag == cfcp_pkg::TAG_LONG || cur_tag == cfcp_pkg::TAG_DOUBLE)
           ? 17'd2 : 17'd1);
    walk_pos = 4'd0;
    if (nxt >= {1'b0, pool_count}) begin
      walk_phase = cfcp_pkg::PH_DONE;
      return 1'b1;
    end
    cur_entry  = nxt[15:0];
    walk_phase = cfcp_pkg::PH_TAG;
    return 1'b0;
  endfunction

  // Advance the parse by one byte; emitted is high when a field completes
  task automatic parse_byte(input logic [7:0] b, input logic fs,
                            output bit emitted, output cfcp_pkg::token_t tok);
    logic [15:0]       ent;
    logic [7:0]        tg;
    cfcp_pkg::layout_t slot;
    logic [31:0]       val;
    ent     = cur_entry;
    tg      = cur_tag;
    emitted = 1'b0;
    tok     = '0;
    if (fs) clear_walker();
    case (walk_phase)
      cfcp_pkg::PH_HEADER: begin
        if (take_byte(b, (walk_pos == 4'd0) ? cfcp_pkg::HDR_MAGIC_SIZE
                                            : cfcp_pkg::HDR_U2_SIZE)) begin
          val       = shift_acc;
          shift_acc = 32'd0;
          emitted   = 1'b1;
          // header positions line up with the first four kinds
          tok.kind  = cfcp_pkg::kind_e'(walk_pos);
          tok.value = val;
          if (walk_pos < cfcp_pkg::HDR_LAST_POS) begin
            walk_pos = walk_pos + 4'd1;
          end else begin
            pool_count = val[15:0];
            walk_pos   = 4'd0;
            cur_entry  = 16'd1;
            if (pool_count <= 16'd1) begin
              walk_phase   = cfcp_pkg::PH_DONE;
              tok.pool_end = 1'b1;
            end else begin
              walk_phase = cfcp_pkg::PH_TAG;
            end
          end
        end
      end
      cfcp_pkg::PH_TAG: begin
        cur_tag   = b;
        walk_pos  = 4'd0;
        gathered  = 2'd0;
        shift_acc = 32'd0;
        slot      = entry_slot(b, 4'd0);
        emitted   = 1'b1;
        tok.value = {24'd0, b};
        tok.entry = ent;
        tok.tag   = b;
        if (!slot.valid) begin
          walk_phase = cfcp_pkg::PH_ERROR;
          tok.kind   = cfcp_pkg::KIND_BAD_TAG;
        end else begin
          walk_phase = cfcp_pkg::PH_FIELDS;
          tok.kind   = cfcp_pkg::KIND_TAG;
        end
      end
      cfcp_pkg::PH_FIELDS: begin
        slot = entry_slot(tg, walk_pos);
        if (!slot.valid) begin
          walk_phase = cfcp_pkg::PH_ERROR;
        end else if (take_byte(b, field_bytes(slot.kind))) begin
          val       = shift_acc;
          shift_acc = 32'd0;
          emitted   = 1'b1;
          tok.kind  = slot.kind;
          tok.value = val;
          tok.entry = ent;
          tok.tag   = tg;
          if (slot.kind == cfcp_pkg::KIND_UTF8_LEN) begin
            // empty string closes the entry on its length
            if (val == 32'd0) begin
              tok.pool_end = close_entry();
            end else begin
              utf8_left  = val[15:0];
              walk_phase = cfcp_pkg::PH_UTF8;
            end
          end else begin
            walk_pos = walk_pos + 4'd1;
            slot     = entry_slot(tg, walk_pos);
            if (!slot.valid) tok.pool_end = close_entry();
          end
        end
      end
      cfcp_pkg::PH_UTF8: begin
        if (utf8_left != 16'd0) utf8_left = utf8_left - 16'd1;
        emitted      = 1'b1;
        tok.kind     = cfcp_pkg::KIND_UTF8_BYTE;
        tok.value    = {24'd0, b};
        tok.entry    = ent;
        tok.tag      = tg;
        tok.pool_end = (utf8_left == 16'd0) ? close_entry() : 1'b0;
      end
      default: emitted = 1'b0;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stream building
  logic [7:0] good_tags [14] = '{cfcp_pkg::TAG_UTF8, cfcp_pkg::TAG_INT,
                                 cfcp_pkg::TAG_FLOAT, cfcp_pkg::TAG_LONG,
                                 cfcp_pkg::TAG_DOUBLE, cfcp_pkg::TAG_CLASS,
                                 cfcp_pkg::TAG_STRING, cfcp_pkg::TAG_FIELDREF,
                                 cfcp_pkg::TAG_METHODREF, cfcp_pkg::TAG_IMETHODREF,
                                 cfcp_pkg::TAG_NAME_TYPE, cfcp_pkg::TAG_MHANDLE,
                                 cfcp_pkg::TAG_MTYPE, cfcp_pkg::TAG_INDY};

  task automatic put_byte(input logic [7:0] b, input bit live);
    byte_item_t it;
    it.data    = b;
    it.start   = start_next;
    start_next = 1'b0;
    byte_q.push_back(it);
    if (live) live_bytes++;
  endtask

  task automatic put_u2(input logic [15:0] v);
    put_byte(v[15:8], 1'b1);
    put_byte(v[7:0], 1'b1);
  endtask

  task automatic put_u4(input logic [31:0] v);
    put_u2(v[31:16]);
    put_u2(v[15:0]);
  endtask

  task automatic put_header(input logic [31:0] magic, input logic [15:0] minor,
                            input logic [15:0] major, input logic [15:0] count);
    start_next = 1'b1;
    put_u4(magic);
    put_u2(minor);
    put_u2(major);
    put_u2(count);
  endtask

  task automatic put_entry(input logic [7:0] tag, input logic [31:0] a,
                           input logic [31:0] b, input int utf_len);
    put_byte(tag, 1'b1);
    case (tag)
      cfcp_pkg::TAG_UTF8: begin
        put_u2(utf_len[15:0]);
        repeat (utf_len) put_byte(8'($urandom), 1'b1);
      end
      cfcp_pkg::TAG_INT, cfcp_pkg::TAG_FLOAT: put_u4(a);
      cfcp_pkg::TAG_LONG, cfcp_pkg::TAG_DOUBLE: begin
        put_u4(a);
        put_u4(b);
      end
      cfcp_pkg::TAG_CLASS, cfcp_pkg::TAG_STRING, cfcp_pkg::TAG_MTYPE: put_u2(a[15:0]);
      cfcp_pkg::TAG_MHANDLE: begin
        put_byte(a[7:0], 1'b1);
        put_u2(b[15:0]);
      end
      default: begin
        put_u2(a[15:0]);
        put_u2(b[15:0]);
      end
    endcase
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rnd_len();
    if ($urandom_range(0, 7) == 0) return 0;
    if ($urandom_range(0, 29) == 0) return $urandom_range(20, 40);
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [7:0] pick_bad_tag();
    logic [7:0]        t;
    cfcp_pkg::layout_t s;
    t = 8'($urandom);
    s = entry_slot(t, 4'd0);
    while (s.valid) begin
      t = 8'($urandom);
      s = entry_slot(t, 4'd0);
    end
    return t;
  endfunction

  // Entries with random tags and content, at most max_entries of them
  task automatic put_pool(input int count, input int max_entries);
    int         idx;
    int         n;
    logic [7:0] tg;
    idx = 1;
    n   = 0;
    while (idx < count && n < max_entries) begin
      tg = good_tags[$urandom_range(0, 13)];
      put_entry(tg, rnd32(), rnd32(), rnd_len());
      idx += (tg == cfcp_pkg::TAG_LONG || tg == cfcp_pkg::TAG_DOUBLE) ? 2 : 1;
      n++;
    end
  endtask

  task automatic put_junk(input int n);
    repeat (n) put_byte(8'($urandom), 1'b0);
  endtask

  // Zero-wait stretches every few dozen transactions, random waits otherwise
  function automatic int pause_len(input int serial);
    return ((serial / 40) % 3 == 0) ? 0 : int'($urandom_range(0, 9));
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one byte per transaction, changes at the falling edge
  always @(negedge clk_i) begin : feed
    byte_item_t it;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (byte_q.size() != 0) begin
        it = byte_q.pop_front();
        data_byte_i  <= it.data;
        file_start_i <= it.start;
        in_valid_i   <= 1'b1;
        gap_left     <= pause_len(bytes_sent);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: drawn after every accepted token
  always @(negedge clk_i) begin : drain
    int n;
    if (out_fire) begin
      n = pause_len(tokens_taken);
      hold_left   <= n;
      out_stall_i <= (n != 0);
    end else if (hold_left > 1) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      hold_left   <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on accepted bytes, compare accepted tokens
  always @(posedge clk_i) begin : watch
    bit               got;
    cfcp_pkg::token_t tok;
    cfcp_pkg::token_t want;
    in_fire  <= (in_valid_i === 1'b1) && (in_stall_o === 1'b0);
    out_fire <= (out_valid_o === 1'b1) && (out_stall_i === 1'b0);
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        parse_byte(data_byte_i, file_start_i, got, tok);
        if (got) tokens_due.push_back(tok);
        bytes_sent++;
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        tokens_taken++;
        if (tokens_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected token: expected none, got kind %0d value %h",
                   $time, field_kind_o, field_value_o);
        end else begin
          want = tokens_due.pop_front();
          if (field_kind_o !== want.kind) begin
            fails++;
            $display("%0t: field_kind expected %0d got %0d", $time, want.kind,
                     field_kind_o);
          end
          if (field_value_o !== want.value) begin
            fails++;
            $display("%0t: field_value expected %h got %h", $time, want.value,
                     field_value_o);
          end
          if (entry_number_o !== want.entry) begin
            fails++;
            $display("%0t: entry_number expected %0d got %0d", $time, want.entry,
                     entry_number_o);
          end
          if (entry_tag_o !== want.tag) begin
            fails++;
            $display("%0t: entry_tag expected %0d got %0d", $time, want.tag,
                     entry_tag_o);
          end
          if (pool_end_o !== want.pool_end) begin
            fails++;
            $display("%0t: pool_end expected %0d got %0d", $time, want.pool_end,
                     pool_end_o);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_class_file_constant_pool_parser_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  initial begin
    int cnt;
    int mode;
    clear_walker();

    // Out of reset without a file start: header parses anyway, empty pool
    put_u4(32'hCAFE_BABE);
    put_u2(16'h0000);
    put_u2(16'hFFFF);
    put_u2(16'd0);
    put_junk(1);

    // Pool count of one is empty too
    put_header(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'd1);

    // Every tag at least once, extremes in the fields, empty and short strings
    put_header(32'h0000_0000, 16'd0, 16'd52, 16'd18);
    put_entry(cfcp_pkg::TAG_UTF8, 32'd0, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_UTF8, 32'd0, 32'd0, 3);
    put_entry(cfcp_pkg::TAG_INT, 32'd0, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_FLOAT, 32'hFFFF_FFFF, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_LONG, 32'hFFFF_FFFF, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_DOUBLE, 32'd0, 32'hFFFF_FFFF, 0);
    put_entry(cfcp_pkg::TAG_CLASS, 32'hFFFF, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_STRING, 32'd0, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_FIELDREF, 32'd0, 32'hFFFF, 0);
    put_entry(cfcp_pkg::TAG_METHODREF, 32'hFFFF, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_IMETHODREF, $urandom, $urandom, 0);
    put_entry(cfcp_pkg::TAG_NAME_TYPE, $urandom, $urandom, 0);
    put_entry(cfcp_pkg::TAG_MHANDLE, 32'hFF, 32'hFFFF, 0);
    put_entry(cfcp_pkg::TAG_MTYPE, $urandom, 32'd0, 0);
    put_entry(cfcp_pkg::TAG_INDY, $urandom, $urandom, 0);
    put_junk(2);

    // Double in the last slot still ends the pool on its low word
    put_header(32'hCAFE_BABE, 16'd0, 16'd61, 16'd2);
    put_entry(cfcp_pkg::TAG_DOUBLE, $urandom, $urandom, 0);

    // Unknown tags, then everything ignored until the next file
    put_header(32'hCAFE_BABE, 16'd0, 16'd61, 16'd5);
    put_entry(cfcp_pkg::TAG_CLASS, 32'd7, 32'd0, 0);
    put_byte(TAG_ZERO, 1'b1);
    put_junk(3);
    put_header(32'hCAFE_BABE, 16'd3, 16'd45, 16'd3);
    put_byte(TAG_ALL_ONES, 1'b1);
    put_junk(1);

    // Full-size pool count cut off inside a field by a new file
    put_header(32'hCAFE_BABE, 16'd0, 16'd55, 16'hFFFF);
    put_entry(cfcp_pkg::TAG_UTF8, 32'd0, 32'd0, 2);
    put_byte(cfcp_pkg::TAG_INT, 1'b1);
    put_byte(8'($urandom), 1'b1);

    // Random files, mostly well formed
    while (live_bytes < LIVE_TARGET) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          // noise with scattered file starts
          repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(0, 7) == 0) start_next = 1'b1;
            put_byte(8'($urandom), 1'b1);
          end
        end
        1: begin
          // truncated pool, possibly mid-field
          cnt = ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(3, 12);
          put_header(rnd32(), 16'(rnd32()), 16'(rnd32()), cnt[15:0]);
          put_pool(cnt, $urandom_range(0, 3));
          put_byte(good_tags[$urandom_range(0, 13)], 1'b1);
          repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'b1);
        end
        2: begin
          // unknown tag after at most two entries
          cnt = $urandom_range(2, 8);
          put_header(rnd32(), 16'(rnd32()), 16'(rnd32()), cnt[15:0]);
          put_pool(cnt, $urandom_range(0, 2));
          put_byte(pick_bad_tag(), 1'b1);
          put_junk($urandom_range(0, 3));
        end
        default: begin
          cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
          put_header(rnd32(), 16'(rnd32()), 16'(rnd32()), cnt[15:0]);
          put_pool(cnt, cnt);
          put_junk($urandom_range(0, 2));
        end
      endcase
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (tokens_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fails == 0) begin
      $display("tb_class_file_constant_pool_parser_top: done, clean");
    end else begin
      $display("tb_class_file_constant_pool_parser_top: done, errors");
    end
    $finish;
  end

endmodule

// File: class_file_constant_pool_parser_top.f
rtl/cfcp_pkg.sv
rtl/cfcp_front.sv
rtl/cfcp_fifo.sv
rtl/cfcp_back.sv
rtl/class_file_constant_pool_parser_top.sv
rtl/cfcp_checker.sv
sim/tb_class_file_constant_pool_parser_top.sv
